// ===== src/minifloat_matrix_vector_multiply_top_macros.svh =====
// Assertion macros shared by the minifloat matrix-vector multiply modules.
`ifndef MINIFLOAT_MATRIX_VECTOR_MULTIPLY_TOP_MACROS_SVH
`define MINIFLOAT_MATRIX_VECTOR_MULTIPLY_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define MMV_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MMV_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MMV_ASSERT(label, clk, rstn, prop, msg)
`define MMV_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

// ===== src/mmv_pkg.sv =====
// Types and constants for the minifloat matrix-vector multiply.
package mmv_pkg;
    localparam int WORD_W = 13;
    localparam int COL_W  = 3;
    localparam int ACC_W  = 76;
    localparam int EXP_OFFSET = 32;
    localparam logic [5:0] EXP_TOP = 6'd63;
    localparam logic [5:0] FIELD_MAX = 6'h3F;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_MATRIX = 1'b1
    } op_t;

    // Work item handed from the front end to the back end.
    typedef struct packed {
        logic              restart;
        logic              last;
        logic [WORD_W-1:0] mat_word;
        logic [WORD_W-1:0] vec_word;
    } mmv_job_t;
endpackage

// ===== src/mmv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mmv_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/mmv_front.sv =====
// Front end: stores vector words and pairs each matrix word with its vector word.
module mmv_front #(
    parameter int VECTOR_LENGTH = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [mmv_pkg::COL_W-1:0]  s_column,
    input  logic [mmv_pkg::WORD_W-1:0] s_value,
    output logic                       job_valid,
    input  logic                       job_ready,
    output mmv_pkg::mmv_job_t          job
);
    import mmv_pkg::*;

    localparam int AW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
    // Wide enough to hold VECTOR_LENGTH itself, not just the largest column.
    localparam int LW = $clog2(VECTOR_LENGTH + 1);
    localparam int CW = (LW > COL_W) ? LW : COL_W;
    localparam logic [CW-1:0] LEN_C  = CW'(VECTOR_LENGTH);
    localparam logic [CW-1:0] LAST_C = CW'(VECTOR_LENGTH - 1);

    logic              stage_valid_reg;
    logic              stage_restart_reg;
    logic              stage_last_reg;
    logic [WORD_W-1:0] stage_mat_reg;
    logic [WORD_W-1:0] vec_rdata;
    logic [CW-1:0]     col_ext;
    logic              in_range;
    logic              accept;
    logic              is_matrix;
    logic              advance;

    assign col_ext   = CW'(s_column);
    assign in_range  = col_ext < LEN_C;
    assign advance   = !stage_valid_reg || job_ready;
    assign s_ready   = advance;
    assign accept    = s_valid && s_ready;
    assign is_matrix = s_op == OP_MATRIX;

    // The registered RAM read data lines up with the stage register.
    mmv_ram #(.WIDTH(WORD_W), .DEPTH(VECTOR_LENGTH)) u_vec_ram (
        .aclk  (aclk),
        .we    (accept && !is_matrix && in_range),
        .waddr (AW'(s_column)),
        .wdata (s_value),
        .re    (accept && is_matrix && in_range),
        .raddr (AW'(s_column)),
        .rdata (vec_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (advance) begin
            stage_valid_reg <= accept && is_matrix && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_restart_reg <= col_ext == '0;
            stage_last_reg    <= col_ext == LAST_C;
            stage_mat_reg     <= s_value;
        end
    end

    assign job_valid    = stage_valid_reg;
    assign job.restart  = stage_restart_reg;
    assign job.last     = stage_last_reg;
    assign job.mat_word = stage_mat_reg;
    assign job.vec_word = vec_rdata;

    `include "minifloat_matrix_vector_multiply_top_macros.svh"
    `MMV_ASSERT(a_stage_holds, aclk, aresetn,
        (job_valid && !job_ready) |=> (job_valid && $stable(job.mat_word)),
        "front stage lost a stalled job")
    `MMV_ASSERT(a_load_no_job, aclk, aresetn,
        (accept && !is_matrix) |=> !job_valid, "vector load produced a job")
    `MMV_ASSERT(a_ready_when_empty, aclk, aresetn,
        !stage_valid_reg |-> s_ready, "front stalled while empty")
endmodule

// ===== src/mmv_fifo.sv =====
// Two-entry job queue between the front end and the back end.
module mmv_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  mmv_pkg::mmv_job_t in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output mmv_pkg::mmv_job_t out_job
);
    import mmv_pkg::*;

    mmv_job_t   slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = slot_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= !wptr_reg;
            end
            if (pop) begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= in_job;
        end
    end

    `include "minifloat_matrix_vector_multiply_top_macros.svh"
    `MMV_ASSERT_NEVER(a_no_overflow, aclk, aresetn, count_reg == 2'd3,
        "queue count out of range")
    `MMV_ASSERT(a_count_track, aclk, aresetn,
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1), "queue count slip")
    `MMV_ASSERT(a_ptr_match, aclk, aresetn,
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wptr_reg == rptr_reg),
        "queue pointers disagree with count")
endmodule

// ===== src/mmv_back.sv =====
// Back end: multiply, align, accumulate, and encode the row sum.
module mmv_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  mmv_pkg::mmv_job_t          job,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [mmv_pkg::WORD_W-1:0] m_result_word,
    output logic [mmv_pkg::COL_W-1:0]  m_row
);
    import mmv_pkg::*;

    // Stage 1: mantissa product and exponent.
    logic              p1_valid_reg;
    logic              p1_restart_reg;
    logic              p1_last_reg;
    logic              p1_neg_reg;
    logic [13:0]       p1_prod_reg;
    logic [7:0]        p1_esum_reg;
    // Stage 2: signed aligned term and accumulate.
    logic              p2_valid_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    // Stage 3: magnitude and leading one.
    logic              p3_valid_reg;
    logic              p3_sign_reg;
    logic [ACC_W-1:0]  p3_mag_reg;
    // Output register.
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [COL_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  row_count_reg;

    logic              advance;
    logic              high;
    logic signed [8:0] es;
    logic [5:0]        e_prod;
    logic [6:0]        m_prod;
    logic [ACC_W-1:0]  term_mag;
    logic [ACC_W-1:0]  term;
    logic [ACC_W-1:0]  base;
    logic [ACC_W-1:0]  raw_sum;
    logic [ACC_W-1:0]  neg_sum;
    logic [6:0]        pos;
    logic              found;
    logic [7:0]        mant;
    logic [6:0]        e_enc;
    logic [WORD_W-1:0] enc_word;
    logic [ACC_W-1:0]  win;

    // The whole pipe moves together; the output register decouples the consumer.
    assign advance   = !out_valid_reg || m_ready || !p3_valid_reg;
    assign job_ready = advance;

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_restart_reg <= job.restart;
            p1_last_reg    <= job.last;
            p1_neg_reg     <= job.mat_word[12] ^ job.vec_word[12];
            p1_prod_reg    <= {8'd1, job.mat_word[5:0]} * {8'd1, job.vec_word[5:0]};
            p1_esum_reg    <= {2'd0, job.mat_word[11:6]} + {2'd0, job.vec_word[11:6]};
        end
    end

    assign high = p1_prod_reg[13];
    assign es   = $signed({1'b0, p1_esum_reg}) - 9'sd32 + $signed({8'd0, high});

    always_comb begin
        if (es < 0) begin
            e_prod = 6'd0;
            m_prod = 7'd64;
        end else if (es > 9'sd63) begin
            e_prod = EXP_TOP;
            m_prod = 7'd127;
        end else begin
            e_prod = es[5:0];
            m_prod = {1'b1, high ? p1_prod_reg[12:7] : p1_prod_reg[11:6]};
        end
        term_mag = ACC_W'(m_prod) << e_prod;
        term     = p1_neg_reg ? (~term_mag + ACC_W'(1)) : term_mag;
        base     = p1_restart_reg ? '0 : acc_reg;
        raw_sum  = base + term;
        if (base[ACC_W-1] == term[ACC_W-1] && raw_sum[ACC_W-1] != base[ACC_W-1]) begin
            acc_next = base[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_next = raw_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end else if (advance) begin
            p1_valid_reg <= job_valid;
            p2_valid_reg <= p1_valid_reg && p1_last_reg;
            p3_valid_reg <= p2_valid_reg;
            if (p1_valid_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign neg_sum = ~acc_reg + ACC_W'(1);

    always_ff @(posedge aclk) begin
        if (advance) begin
            p3_sign_reg <= acc_reg[ACC_W-1];
            p3_mag_reg  <= acc_reg[ACC_W-1] ? neg_sum : acc_reg;
        end
    end

    always_comb begin
        pos   = '0;
        found = 1'b0;
        for (int k = 0; k < ACC_W; k++) begin
            if (p3_mag_reg[k]) begin
                pos   = 7'(k);
                found = 1'b1;
            end
        end
        // Bits p..p-7 brought to the bottom of the window.
        win   = (pos >= 7'd7) ? (p3_mag_reg >> (pos - 7'd7))
                              : (p3_mag_reg << (7'd7 - pos));
        mant  = {1'b0, win[7:1]} + {7'd0, (pos >= 7'd7) ? win[0] : 1'b0};
        e_enc = pos - 7'd6;
        if (mant == 8'd128) begin
            mant  = 8'd64;
            e_enc = e_enc + 7'd1;
        end
        if (!found) begin
            enc_word = '0;
        end else if (pos < 7'd6) begin
            enc_word = {p3_sign_reg, 12'd0};
        end else if (pos > 7'd69 || e_enc > 7'd63) begin
            enc_word = {p3_sign_reg, EXP_TOP, FIELD_MAX};
        end else begin
            enc_word = {p3_sign_reg, e_enc[5:0], mant[5:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            row_count_reg <= '0;
        end else begin
            if (advance && p3_valid_reg) begin
                out_valid_reg <= 1'b1;
                row_count_reg <= row_count_reg + COL_W'(1);
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && p3_valid_reg) begin
            out_word_reg <= enc_word;
            out_row_reg  <= row_count_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_word = out_word_reg;
    assign m_row         = out_row_reg;

    `include "minifloat_matrix_vector_multiply_top_macros.svh"
    `MMV_ASSERT(a_out_hold, aclk, aresetn,
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_word)),
        "result changed while stalled")
    `MMV_ASSERT(a_row_step, aclk, aresetn,
        (advance && p3_valid_reg) |=> (row_count_reg == $past(row_count_reg) + 3'd1),
        "row counter missed a result")
    `MMV_ASSERT(a_zero_word, aclk, aresetn,
        (p3_valid_reg && p3_mag_reg == '0) |-> (enc_word == '0),
        "zero sum not encoded as floor word")
endmodule

// ===== src/minifloat_matrix_vector_multiply_top.sv =====
// Top level of the minifloat matrix-vector multiply.
//
// Channel   Dir  Ports
// s_        in   s_valid s_ready s_op s_column s_value
// m_        out  m_valid m_ready m_result_word m_row
//
// One word is accepted every cycle while s_ready is high; vector loads and matrix words alike.
// A matrix word passes the front stage, queue, multiply, accumulate and magnitude
// registers to the encoded result register; only a row's last word gives a result.
// Reset clears all control state and the row sum; the vector store is not cleared.
// A stalled result with another row sum behind it stops the back-end pipe; the
// two-entry queue then fills before the input side deasserts s_ready.
module minifloat_matrix_vector_multiply_top #(
    parameter int VECTOR_LENGTH = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [mmv_pkg::COL_W-1:0]  s_column,
    input  logic [mmv_pkg::WORD_W-1:0] s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [mmv_pkg::WORD_W-1:0] m_result_word,
    output logic [mmv_pkg::COL_W-1:0]  m_row
);
    import mmv_pkg::*;

    mmv_job_t front_job;
    mmv_job_t q_job;
    logic     front_valid;
    logic     front_ready;
    logic     q_valid;
    logic     q_ready;

    mmv_front #(.VECTOR_LENGTH(VECTOR_LENGTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_column  (s_column),
        .s_value   (s_value),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    mmv_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    mmv_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (q_valid),
        .job_ready     (q_ready),
        .job           (q_job),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_word (m_result_word),
        .m_row         (m_row)
    );
endmodule
